/* rtl/mbet_pkg.sv */
// Shared types, widths, constants and helpers for the Mandelbrot escape-time block.
package mbet_pkg;

    // Fixed-point word and derived widths.
    localparam int W          = 32;
    localparam int FRAC_BITS  = 27;
    localparam int PIXEL_BITS = 12;
    localparam int STEP_W     = W - 1;
    localparam int CNT_W      = 10;
    localparam int GRAY_W     = 8;
    localparam int PROD_W     = 2 * W;
    localparam int SQ_W       = PROD_W - FRAC_BITS;
    localparam int ACC_W      = SQ_W + 1;
    localparam int DVD_W      = CNT_W + GRAY_W;
    localparam int DSR_W      = CNT_W + GRAY_W - 1;
    localparam int DSTEP_W    = $clog2(GRAY_W);
    localparam int CFG_IDX_W  = 3;

    // Escape threshold, four at the working scale.
    localparam logic signed [ACC_W-1:0] FOUR = ACC_W'(4) << FRAC_BITS;

    // Saturation bounds of the 32-bit word, seen in product width.
    localparam logic signed [PROD_W-1:0] SAT_HI = {{(PROD_W-W+1){1'b0}}, {(W-1){1'b1}}};
    localparam logic signed [PROD_W-1:0] SAT_LO = {{(PROD_W-W+1){1'b1}}, {(W-1){1'b0}}};

    // Register reset values.
    localparam logic signed [W-1:0]  ORIGIN_RE_RST = -32'sd268435456;
    localparam logic signed [W-1:0]  ORIGIN_IM_RST = -32'sd134217728;
    localparam logic [STEP_W-1:0]    STEP_RE_RST   = 31'd393216;
    localparam logic [STEP_W-1:0]    STEP_IM_RST   = 31'd372827;
    localparam logic [CNT_W-1:0]     MAX_ITER_RST  = 10'd100;

    // Configuration register indices.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ORIGIN_RE = 3'd0,
        CFG_ORIGIN_IM = 3'd1,
        CFG_STEP_RE   = 3'd2,
        CFG_STEP_IM   = 3'd3,
        CFG_MAX_ITER  = 3'd4
    } t_cfg_idx;

    // Handshake between the sequencer and the gray-level divider.
    typedef struct packed {
        logic             start;
        logic [CNT_W-1:0] count;
        logic [CNT_W-1:0] limit;
    } t_div_req;

    typedef struct packed {
        logic              done;
        logic [GRAY_W-1:0] gray;
    } t_div_rsp;

    // Clamp a wide signed value to the 32-bit signed range.
    function automatic logic signed [W-1:0] sat_w(input logic signed [PROD_W-1:0] v);
        logic signed [W-1:0] res;
        if (v > SAT_HI) begin
            res = SAT_HI[W-1:0];
        end else if (v < SAT_LO) begin
            res = SAT_LO[W-1:0];
        end else begin
            res = v[W-1:0];
        end
        return res;
    endfunction

endpackage

/* rtl/mbet_gray_div.sv */
// Restoring divider that forms floor(255 * count / limit), one quotient bit per cycle.
module mbet_gray_div
    import mbet_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_div_req i_req,
    output t_div_rsp o_rsp
);

    logic               r_busy;
    logic               r_done;
    logic               r_zero;
    logic [DVD_W-1:0]   r_rem;
    logic [DSR_W-1:0]   r_dsr;
    logic [GRAY_W-1:0]  r_quo;
    logic [DSTEP_W-1:0] r_step;
    logic [DVD_W:0]     w_trial;

    // Trial subtraction of the shifted divisor.
    assign w_trial = {1'b0, r_rem} - (DVD_W+1)'(r_dsr);

    // Quotient bits are produced from the most significant down.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            // Done pulses for one cycle after the last quotient bit.
            r_done <= r_busy && !i_req.start && (r_step == DSTEP_W'(GRAY_W - 1));
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_step <= '0;
                r_zero <= (i_req.limit == '0);
                r_rem  <= {i_req.count, {GRAY_W{1'b0}}} - DVD_W'(i_req.count);
                r_dsr  <= {i_req.limit, {(GRAY_W-1){1'b0}}};
                r_quo  <= '0;
            end else if (r_busy) begin
                if (!w_trial[DVD_W]) begin
                    r_rem <= w_trial[DVD_W-1:0];
                end
                r_quo <= {r_quo[GRAY_W-2:0], ~w_trial[DVD_W]};
                r_dsr <= r_dsr >> 1;
                r_step <= r_step + 1'b1;
                if (r_step == DSTEP_W'(GRAY_W - 1)) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    // A zero limit gives a zero gray level.
    assign o_rsp.done = r_done;
    assign o_rsp.gray = r_zero ? '0 : r_quo;

endmodule

/* rtl/mandelbrot_escape_time_top.sv */
// Top level of the Mandelbrot escape-time evaluator: sequencer, shared multiplier and ports.
//
//  Channel   Direction  Contents
//  s_axis    in         pixel transaction: column, row
//  m_axis    out        result transaction: iteration count, escaped flag, gray level
//  i_cfg_*   in         register writes: origin, step and iteration limit
//
// The single 32x32 multiplier is used three times in each iteration of the states S_XX,
// S_YY, S_XY and S_UPD and so sets the pace of a pixel; the gray-level division holds
// the sequencer in S_DIV until the divider reports done.
// Reset is synchronous and active low and restores the register reset values.
// A new pixel is taken while an earlier result still waits on m_axis; the block
// holds a finished result until the output register is free.
module mandelbrot_escape_time_top
    import mbet_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [23:0]          s_axis_tdata,   // [11:0] pixel_column, [23:12] pixel_row
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [23:0]          m_axis_tdata,   // [9:0] iteration_count, [10] escaped,
                                                 // [18:11] gray_level, [23:19] zero
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [W-1:0]         i_cfg_data
);

    typedef enum logic [3:0] {
        S_IDLE, S_CRE, S_CIM, S_CSET, S_XX, S_YY, S_XY, S_UPD, S_DIV, S_FIN
    } t_state;

    t_state                     r_state;
    logic signed [W-1:0]        r_origin_re;
    logic signed [W-1:0]        r_origin_im;
    logic [STEP_W-1:0]          r_step_re;
    logic [STEP_W-1:0]          r_step_im;
    logic [CNT_W-1:0]           r_max_iter;
    logic [PIXEL_BITS-1:0]      r_col;
    logic [PIXEL_BITS-1:0]      r_row;
    logic signed [W-1:0]        r_cre;
    logic signed [W-1:0]        r_cim;
    logic signed [W-1:0]        r_x;
    logic signed [W-1:0]        r_y;
    logic signed [SQ_W-1:0]     r_xx;
    logic signed [SQ_W-1:0]     r_yy;
    logic signed [PROD_W-1:0]   r_prod;
    logic [CNT_W-1:0]           r_count;
    logic                       r_outside;
    logic                       r_div_start;
    logic                       r_m_valid;
    logic [CNT_W-1:0]           r_m_count;
    logic                       r_m_escaped;
    logic [GRAY_W-1:0]          r_m_gray;

    logic signed [W-1:0]        w_mul_a;
    logic signed [W-1:0]        w_mul_b;
    logic signed [PROD_W-1:0]   w_prod;
    logic signed [PROD_W-1:0]   w_sq_sh;
    logic signed [PROD_W-1:0]   w_xy_sh;
    logic signed [ACC_W-1:0]    w_mag;
    logic signed [W-1:0]        w_nx;
    logic signed [W-1:0]        w_ny;
    logic                       w_in_acc;
    logic                       w_out_free;
    t_div_req                   w_div_req;
    t_div_rsp                   w_div_rsp;

    // Shared multiplier: operands follow the sequencer step.
    always_comb begin
        case (r_state)
            S_CRE: begin
                w_mul_a = $signed({1'b0, r_step_re});
                w_mul_b = $signed(W'(r_col));
            end
            S_CIM: begin
                w_mul_a = $signed({1'b0, r_step_im});
                w_mul_b = $signed(W'(r_row));
            end
            S_XX: begin
                w_mul_a = r_x;
                w_mul_b = r_x;
            end
            S_YY: begin
                w_mul_a = r_y;
                w_mul_b = r_y;
            end
            S_XY: begin
                w_mul_a = r_x;
                w_mul_b = r_y;
            end
            default: begin
                w_mul_a = '0;
                w_mul_b = '0;
            end
        endcase
    end

    assign w_prod = w_mul_a * w_mul_b;

    // Arithmetic shifts round towards minus infinity.
    assign w_sq_sh = r_prod >>> FRAC_BITS;
    assign w_xy_sh = r_prod >>> (FRAC_BITS - 1);

    // Magnitude test and the next point of the orbit.
    assign w_mag = ACC_W'(r_xx) + ACC_W'(r_yy);
    assign w_nx  = sat_w(PROD_W'(r_xx) - PROD_W'(r_yy) + PROD_W'(r_cre));
    assign w_ny  = sat_w(w_xy_sh + PROD_W'(r_cim));

    assign w_in_acc   = s_axis_tvalid && s_axis_tready;
    assign w_out_free = !r_m_valid || m_axis_tready;

    // Gray-level divider.
    assign w_div_req.start = r_div_start;
    assign w_div_req.count = r_count;
    assign w_div_req.limit = r_max_iter;

    mbet_gray_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_div_req),
        .o_rsp   (w_div_rsp)
    );

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_origin_re <= ORIGIN_RE_RST;
            r_origin_im <= ORIGIN_IM_RST;
            r_step_re   <= STEP_RE_RST;
            r_step_im   <= STEP_IM_RST;
            r_max_iter  <= MAX_ITER_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_ORIGIN_RE: r_origin_re <= $signed(i_cfg_data);
                CFG_ORIGIN_IM: r_origin_im <= $signed(i_cfg_data);
                CFG_STEP_RE:   r_step_re   <= i_cfg_data[STEP_W-1:0];
                CFG_STEP_IM:   r_step_im   <= i_cfg_data[STEP_W-1:0];
                CFG_MAX_ITER:  r_max_iter  <= i_cfg_data[CNT_W-1:0];
                default: ;
            endcase
        end
    end

    // Sequencer with the orbit registers and the output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_div_start <= 1'b0;
            r_m_valid   <= 1'b0;
        end else begin
            // The division starts once the orbit has stopped, by limit or by escape.
            r_div_start <= ((r_state == S_XX) && (r_count >= r_max_iter))
                        || ((r_state == S_UPD) && (w_mag >= FOUR));
            r_prod      <= w_prod;
            // A result leaves unless a new one replaces it in the same cycle.
            if (r_m_valid && m_axis_tready && (r_state != S_FIN)) begin
                r_m_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (w_in_acc) begin
                        r_col   <= s_axis_tdata[PIXEL_BITS-1:0];
                        r_row   <= s_axis_tdata[12 +: PIXEL_BITS];
                        r_state <= S_CRE;
                    end
                end
                S_CRE: begin
                    r_state <= S_CIM;
                end
                S_CIM: begin
                    r_cre   <= sat_w(PROD_W'(r_origin_re) + r_prod);
                    r_state <= S_CSET;
                end
                S_CSET: begin
                    r_cim     <= sat_w(PROD_W'(r_origin_im) + r_prod);
                    r_x       <= '0;
                    r_y       <= '0;
                    r_count   <= '0;
                    r_outside <= 1'b0;
                    r_state   <= S_XX;
                end
                S_XX: begin
                    if (r_count >= r_max_iter) begin
                        r_state <= S_DIV;
                    end else begin
                        r_state <= S_YY;
                    end
                end
                S_YY: begin
                    r_xx    <= w_sq_sh[SQ_W-1:0];
                    r_state <= S_XY;
                end
                S_XY: begin
                    r_yy    <= w_sq_sh[SQ_W-1:0];
                    r_state <= S_UPD;
                end
                S_UPD: begin
                    if (w_mag >= FOUR) begin
                        r_outside <= 1'b1;
                        r_state   <= S_DIV;
                    end else begin
                        r_x     <= w_nx;
                        r_y     <= w_ny;
                        r_count <= r_count + 1'b1;
                        r_state <= S_XX;
                    end
                end
                S_DIV: begin
                    if (w_div_rsp.done) begin
                        r_state <= S_FIN;
                    end
                end
                S_FIN: begin
                    // The divider holds its quotient until the next start.
                    if (w_out_free) begin
                        r_m_valid   <= 1'b1;
                        r_m_count   <= r_count;
                        r_m_escaped <= r_outside;
                        r_m_gray    <= w_div_rsp.gray;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // Port drive.
    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = {5'd0, r_m_gray, r_m_escaped, r_m_count};

endmodule

/* rtl/mbet_checker.sv */
// Port-level checks on the Mandelbrot escape-time top level, bound to it.
module mbet_checker (
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 s_axis_tvalid,
    input logic                 s_axis_tready,
    input logic                 m_axis_tvalid,
    input logic                 m_axis_tready,
    input logic [23:0]          m_axis_tdata
);

    // A stalled result transaction holds its value.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed while stalled");

    // The block is busy in the cycle after it takes a pixel.
    a_busy_after_in: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("pixel taken while the previous one is in work");

    // An escaped point lies below the limit, so its gray level stays under full scale.
    a_escaped_gray: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[10] |-> m_axis_tdata[18:11] != 8'hFF)
        else $error("escaped point with full gray level");

    // No iterations means black.
    a_zero_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[9:0] == 10'd0 |-> m_axis_tdata[18:11] == 8'd0
            && !m_axis_tdata[10])
        else $error("zero count with non-zero gray level or escape");

    // Padding bits stay clear.
    a_pad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tdata[23:19] == 5'd0)
        else $error("padding bits set in result");

endmodule

bind mandelbrot_escape_time_top mbet_checker u_mbet_checker (.*);
